// ===== hw/rtl/log_edge_threshold_5x5_defines.svh =====
// Assertion helpers for the edge detector.
`ifndef LOG_EDGE_THRESHOLD_5X5_DEFINES_SVH
`define LOG_EDGE_THRESHOLD_5X5_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LOGEDGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LOGEDGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/logedge_pkg.sv =====
package logedge_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 5;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int LINES  = 4;
  localparam int WORD_W = LINES * PIX_W;

  // Register reset values
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd120;
  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd512;

  // Binary edge levels
  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  // Result queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  // Register map (index = paddr[3:2])
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  // One result beat
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] edge_val;
  } res_t;

  // Queue entry: one or two results caused by one pixel
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } qent_t;

  // Per-pixel info carried down the pipeline
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             border;
  } pos_t;

endpackage

// ===== hw/rtl/logedge_in_if.sv =====
interface logedge_in_if import logedge_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== hw/rtl/logedge_out_if.sv =====
interface logedge_out_if import logedge_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] edge_pixel;
  logic             last_result;

  modport source (output valid, output out_row, output out_col, output edge_pixel,
                  output last_result, input ready);
  modport sink   (input valid, input out_row, input out_col, input edge_pixel,
                  input last_result, output ready);
endinterface

// ===== hw/rtl/log_edge_threshold_5x5.sv =====
// Streaming 5x5 Laplacian-of-Gaussian edge detector with a binary threshold.
// One pixel beat is taken per clock while the 8-entry result queue has room
// for it and all pixels in flight. Stages: accept and line-store read, store
// write-back and window shift, partial sums, final sum and threshold. A pixel
// yields zero, one or two result beats; the output side moves one beat per
// clock while the receiver is ready, so the input rate is one pixel per clock
// except where border pixels give two results each; then the output port
// sets the pace. The four line stores sit in one 1024 x 32 memory, one word
// per column, read and written once per pixel. Entries never written since
// reset read as zero through a fill count, so need no clearing after reset.
// Registers (APB, 32-bit): 0x0 edge_threshold, 0x4 image_width,
// 0x8 image_height; sizes act as clamped to 5..1024 and 5..4096.
`include "log_edge_threshold_5x5_defines.svh"

module log_edge_threshold_5x5 import logedge_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  logedge_in_if.sink          in_chan,
  logedge_out_if.source       out_chan,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  // ---------------- configuration ----------------
  logic [PIX_W-1:0] thresh_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: thresh_r <= cfg_pwdata[PIX_W-1:0];
        REG_WIDTH:     width_r  <= cfg_pwdata[WID_W-1:0];
        REG_HEIGHT:    height_r <= cfg_pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: cfg_prdata = {{(32-PIX_W){1'b0}}, thresh_r};
      REG_WIDTH:     cfg_prdata = {{(32-WID_W){1'b0}}, width_r};
      REG_HEIGHT:    cfg_prdata = {{(32-HGT_W){1'b0}}, height_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Effective (clamped) frame size
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    if (width_r < WID_W'(MIN_SIZE))       w_eff = WID_W'(MIN_SIZE);
    else if (width_r > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else                                  w_eff = width_r;
    if (height_r < HGT_W'(MIN_SIZE))        h_eff = HGT_W'(MIN_SIZE);
    else if (height_r > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else                                    h_eff = height_r;
  end

  // ---------------- pipeline registers ----------------
  logic             s1_v_r, s2_v_r, s3_v_r;
  pos_t             s1_pos_r, s2_pos_r, s3_pos_r;
  logic             s1_fwd_r, s1_live_r;
  logic [WORD_W-1:0] rd_word_r, fwd_word_r;
  logic [PIX_W-1:0] s3_pa_r;
  logic [9:0]       s3_pb_r;
  logic [10:0]      s3_pc_r;

  // ---------------- accept stage ----------------
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt, cur_row;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt, cur_col;
  logic [WID_W-1:0] fill_r, fill_nxt, col_inc;
  logic [HGT_W-1:0] row_inc;
  logic             in_fire, cur_int, cur_bord;
  logic [4:0]       occupancy;
  logic [QCNT_W-1:0] q_cnt_r;

  assign occupancy = 5'(q_cnt_r) + 5'(s1_v_r) + 5'(s2_v_r) + 5'(s3_v_r);
  assign in_chan.ready = occupancy < 5'(QDEPTH);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign cur_row = in_chan.frame_start ? '0 : row_cnt_r;
  assign cur_col = in_chan.frame_start ? '0 : col_cnt_r;
  assign col_inc = {1'b0, cur_col} + WID_W'(1);
  assign row_inc = {1'b0, cur_row} + HGT_W'(1);

  // Window centered two rows up, two columns left is complete and interior
  assign cur_int = (cur_row >= ROW_W'(4)) && (cur_col >= COL_W'(4)) &&
                   ({1'b0, cur_row} < h_eff) && ({1'b0, cur_col} < w_eff);
  // Incoming pixel lies on the border band
  assign cur_bord = (cur_row < ROW_W'(2)) || (cur_col < COL_W'(2)) ||
                    ({1'b0, cur_row} + HGT_W'(2) >= h_eff) ||
                    ({1'b0, cur_col} + WID_W'(2) >= w_eff);

  // Position advance and written-column fill count
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    fill_nxt    = fill_r;
    if (in_fire) begin
      if (col_inc >= w_eff) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_cnt_nxt = col_inc[COL_W-1:0];
        row_cnt_nxt = cur_row;
      end
      if (col_inc > fill_r) fill_nxt = col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      fill_r    <= '0;
      s1_v_r    <= 1'b0;
      s1_fwd_r  <= 1'b0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      fill_r    <= fill_nxt;
      s1_v_r    <= in_fire;
      // same column still being written back by stage 1
      s1_fwd_r  <= in_fire && s1_v_r && (s1_pos_r.col == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r  <= '{pix: in_chan.pixel, row: cur_row, col: cur_col,
                     interior: cur_int, border: cur_bord};
      s1_live_r <= {1'b0, cur_col} < fill_r;
    end
  end

  // ---------------- line store ----------------
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] lines, wr_word;

  always_ff @(posedge clk) begin
    if (in_fire) rd_word_r <= line_mem[cur_col];
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) line_mem[s1_pos_r.col] <= wr_word;
  end

  // ---------------- stage 1: write-back and window shift ----------------
  always_comb begin
    if (s1_fwd_r)       lines = fwd_word_r;
    else if (s1_live_r) lines = rd_word_r;
    else                lines = '0;
  end

  // Each line moves up one row; the new pixel becomes the newest line
  assign wr_word = {s1_pos_r.pix, lines[WORD_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (s1_v_r) fwd_word_r <= wr_word;
  end

  logic [PIX_W-1:0] win_r [5][5];
  logic [PIX_W-1:0] column [5];

  always_comb begin
    for (int i = 0; i < LINES; i++) column[i] = lines[i*PIX_W +: PIX_W];
    column[LINES] = s1_pos_r.pix;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) win_r[i][j] <= win_r[i][j+1];
        win_r[i][4] <= column[i];
      end
    end
  end

  // ---------------- stage 2: partial sums ----------------
  logic [9:0]  ring_sum;
  logic [10:0] outer_sum;

  assign ring_sum = {2'b0, win_r[1][2]} + {2'b0, win_r[2][1]} +
                    {2'b0, win_r[2][3]} + {2'b0, win_r[3][2]};
  assign outer_sum = {3'b0, win_r[0][2]} + {3'b0, win_r[1][1]} +
                     {3'b0, win_r[1][3]} + {3'b0, win_r[2][0]} +
                     {3'b0, win_r[2][4]} + {3'b0, win_r[3][1]} +
                     {3'b0, win_r[3][3]} + {3'b0, win_r[4][2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) s2_pos_r <= s1_pos_r;
    if (s2_v_r) begin
      s3_pos_r <= s2_pos_r;
      s3_pa_r  <= win_r[2][2];
      s3_pb_r  <= ring_sum;
      s3_pc_r  <= outer_sum;
    end
  end

  // ---------------- stage 3: final sum, threshold, results ----------------
  logic signed [13:0] log_sum;
  logic [PIX_W-1:0]   sat_val;
  res_t               res_int, res_bord;
  qent_t              q_in;
  logic               q_push;

  // center x16, ring x-2, outer x-1
  assign log_sum = $signed({2'b0, s3_pa_r, 4'b0}) - $signed({3'b0, s3_pb_r, 1'b0}) -
                   $signed({3'b0, s3_pc_r});

  always_comb begin
    if (log_sum < 0)                  sat_val = '0;
    else if (log_sum > 14'sd255)      sat_val = EDGE_ON;
    else                              sat_val = log_sum[PIX_W-1:0];
  end

  always_comb begin
    res_int.row       = s3_pos_r.row - ROW_W'(2);
    res_int.col       = s3_pos_r.col - COL_W'(2);
    res_int.edge_val  = (sat_val > thresh_r) ? EDGE_ON : EDGE_OFF;
    res_bord.row      = s3_pos_r.row;
    res_bord.col      = s3_pos_r.col;
    res_bord.edge_val = (s3_pos_r.pix > thresh_r) ? EDGE_ON : EDGE_OFF;
    q_in.two          = s3_pos_r.interior && s3_pos_r.border;
    q_in.first        = s3_pos_r.interior ? res_int : res_bord;
    q_in.second       = res_bord;
  end

  assign q_push = s3_v_r && (s3_pos_r.interior || s3_pos_r.border);

  // ---------------- result queue ----------------
  qent_t             q_mem [QDEPTH];
  qent_t             q_head;
  logic [QPTR_W-1:0] q_wr_r, q_rd_r;
  logic              sel_r, out_beat, q_pop, out_last;

  assign q_head   = q_mem[q_rd_r];
  assign out_last = !q_head.two || sel_r;
  assign out_chan.valid       = q_cnt_r != '0;
  assign out_chan.out_row     = sel_r ? q_head.second.row      : q_head.first.row;
  assign out_chan.out_col     = sel_r ? q_head.second.col      : q_head.first.col;
  assign out_chan.edge_pixel  = sel_r ? q_head.second.edge_val : q_head.first.edge_val;
  assign out_chan.last_result = out_last;
  assign out_beat = out_chan.valid && out_chan.ready;
  assign q_pop    = out_beat && out_last;

  always_ff @(posedge clk) begin
    if (q_push) q_mem[q_wr_r] <= q_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
      sel_r   <= 1'b0;
    end else begin
      if (q_push) q_wr_r <= q_wr_r + QPTR_W'(1);
      if (q_pop)  q_rd_r <= q_rd_r + QPTR_W'(1);
      case ({q_push, q_pop})
        2'b10:   q_cnt_r <= q_cnt_r + QCNT_W'(1);
        2'b01:   q_cnt_r <= q_cnt_r - QCNT_W'(1);
        default: ;
      endcase
      if (out_beat) sel_r <= !out_last;
    end
  end

  // ---------------- assertions ----------------
  `LOGEDGE_ASSERT_NOW(a_queue_no_overflow, q_push, (q_cnt_r < QCNT_W'(QDEPTH)) || q_pop, "result queue overflow")
  `LOGEDGE_ASSERT_NOW(a_edge_binary, out_chan.valid, (out_chan.edge_pixel == EDGE_ON) || (out_chan.edge_pixel == EDGE_OFF), "edge value not binary")
  `LOGEDGE_ASSERT_NOW(a_fwd_same_col, s1_v_r && s1_fwd_r, s1_pos_r.col == $past(s1_pos_r.col), "forwarding without matching column")
  `LOGEDGE_ASSERT_NEXT(a_second_follows, out_beat && !out_last, out_chan.valid && sel_r, "second result of a pixel lost")

endmodule

// ===== test/tb_log_edge_threshold_5x5.sv =====
module tb_log_edge_threshold_5x5 import logedge_pkg::*;;

  localparam int SETTLE_CYCLES = 16;        // pipeline depth plus margin
  localparam int HOLD_CYCLES   = 80;        // long receiver hold-off
  localparam int RANDOM_ITEMS  = 180;
  localparam int TIME_LIMIT    = 2_000_000;
  localparam logic [1:0] SPARE_REG = 2'd3;  // unmapped register slot

  // 5x5 LoG taps: centre 16, inner ring -2/-1, outer cross -1
  localparam int LOG_TAPS [5][5] = '{
    '{ 0,  0, -1,  0,  0},
    '{ 0, -1, -2, -1,  0},
    '{-1, -2, 16, -2, -1},
    '{ 0, -1, -2, -1,  0},
    '{ 0,  0, -1,  0,  0}
  };

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] level;
    logic             last;
  } edge_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logedge_in_if  in_chan();
  logedge_out_if out_chan();

  log_edge_threshold_5x5 dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Edge-map model state
  logic [PIX_W-1:0] line_mem [LINES][MAX_WIDTH];
  logic [PIX_W-1:0] win_mem [5][5];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [PIX_W-1:0] thresh_reg;
  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;

  edge_beat_t edges_due[$];
  int         fail_count = 0;
  bit         in_gaps;
  bit         out_gaps;
  int         hold_seq;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Grey levels biased toward the extremes to push the sum both ways
  function automatic logic [PIX_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_THRESHOLD: return 32'(thresh_reg);
      REG_WIDTH:     return 32'(width_reg);
      REG_HEIGHT:    return 32'(height_reg);
      default:       return '0;
    endcase
  endfunction

  // Advance the model by one pixel and queue the edge beats it releases
  task automatic predict_edges(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    logic [PIX_W-1:0] stack [5];
    int               acc;
    int               level;
    bit               on_border;
    edge_beat_t       b;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;

    // column of four stored lines plus the new pixel, shifted up one line
    for (int i = 0; i < LINES; i++) stack[i] = line_mem[i][c];
    stack[4] = pix;
    for (int i = 0; i < LINES; i++) line_mem[i][c] = stack[i+1];
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win_mem[i][j] = win_mem[i][j+1];
      win_mem[i][4] = stack[i];
    end

    on_border = (r < 2) || (c < 2) || (r + 2 >= h) || (c + 2 >= w);

    // interior pixel two rows and two columns back
    if (r >= 4 && c >= 4 && r < h && c < w) begin
      acc = 0;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++) acc += LOG_TAPS[i][j] * int'(win_mem[i][j]);
      level = (acc < 0) ? 0 : (acc > 255) ? 255 : acc;
      b.row   = ROW_W'(r - 2);
      b.col   = COL_W'(c - 2);
      b.level = (level > int'(thresh_reg)) ? EDGE_ON : EDGE_OFF;
      b.last  = !on_border;
      edges_due.push_back(b);
    end

    // border pixel thresholds its own level
    if (on_border) begin
      b.row   = ROW_W'(r);
      b.col   = COL_W'(c);
      b.level = (pix > thresh_reg) ? EDGE_ON : EDGE_OFF;
      b.last  = 1'b1;
      edges_due.push_back(b);
    end

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Offer one pixel beat; valid stays up unless a gap follows
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    in_chan.valid       <= 1'b1;
    in_chan.pixel       <= pix;
    in_chan.frame_start <= fs;
    do @(posedge clk); while (!in_chan.ready);
    predict_edges(pix, fs);
    gap = in_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering, let every expected beat out, then let the pipe settle
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (edges_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (idx != SPARE_REG && got !== reg_value(idx)) begin
      $display("%0t: register %0d readback: expected %0h, got %0h",
               $time, idx, reg_value(idx), got);
      fail_count++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_THRESHOLD: thresh_reg = val[PIX_W-1:0];
      REG_WIDTH:     width_reg  = val[WID_W-1:0];
      REG_HEIGHT:    height_reg = val[HGT_W-1:0];
      default:       ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  // Reset values, then the threshold at and just above its default
  task automatic test_reset_values();
    check_reg(REG_THRESHOLD);
    check_reg(REG_WIDTH);
    check_reg(REG_HEIGHT);
    send_pixel(8'd121, 1'b1);
    send_pixel(8'd120, 1'b0);
  endtask

  // One 5x5 frame: sizes below the minimum, an unmapped write, one
  // interior pixel saturating high, border beats of both levels
  task automatic test_single_frame();
    wait_drained();
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(SPARE_REG, 32'hFFFF_FFFF);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        send_pixel((r == 2 && c == 2) || r == 0 || r == 4 ? 8'd255 : 8'd0,
                   r == 0 && c == 0);
  endtask

  // Frame wraps without frame_start, then the width shrinks under the
  // current column so the next pixel is border and the position wraps
  task automatic test_resize_mid_row();
    wait_drained();
    write_reg(REG_WIDTH, 32'd7);
    write_reg(REG_THRESHOLD, 32'd255);
    for (int i = 0; i < 6; i++) send_pixel(pick_level(), 1'b0);
    wait_drained();
    write_reg(REG_WIDTH, 32'd5);
    send_pixel(8'd255, 1'b0);
  endtask

  // Random frames with random content; a few stray frame marks
  task automatic test_random_frames();
    int k;
    int sent;
    int burst;
    int w;
    int h;
    k = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      in_gaps  = (k % 3) != 1;
      out_gaps <= (k % 4) != 2;
      case (k)
        0: begin
          w = 2047;
          h = 8191;
          write_reg(REG_THRESHOLD, 32'd0);
        end
        1: begin
          w = MAX_WIDTH;
          h = MAX_HEIGHT;
          write_reg(REG_THRESHOLD, 32'd255);
        end
        default: begin
          w = $urandom_range(5, 10);
          h = $urandom_range(5, 8);
          write_reg(REG_THRESHOLD, 32'($urandom_range(0, 255)));
        end
      endcase
      write_reg(REG_WIDTH, 32'(w));
      write_reg(REG_HEIGHT, 32'(h));
      if ($urandom_range(0, 3) == 0) write_reg(SPARE_REG, $urandom);
      burst = (k < 2) ? 24 : w * h + $urandom_range(0, w * h);
      for (int i = 0; i < burst; i++)
        send_pixel(pick_level(),
                   i == 0 ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 49) == 0));
      sent += burst;
      k++;
    end
  endtask

  // Receiver holds off while pixels keep coming: queue fills, input stalls
  task automatic test_output_hold();
    wait_drained();
    write_reg(REG_WIDTH, 32'd8);
    write_reg(REG_HEIGHT, 32'd6);
    write_reg(REG_THRESHOLD, 32'($urandom_range(0, 255)));
    in_gaps = 0;
    out_gaps <= 1'b1;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 40; i++) send_pixel(pick_level(), i == 0);
    in_gaps = 1;
  endtask

  // Result side ready: random stalls plus requested long hold-offs
  initial begin : result_side
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = out_gaps ? pick_gap() : 0;
        if (stall_left > 0) begin
          stall_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted edge beat with the oldest expectation
  always @(posedge clk) begin
    edge_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (edges_due.size() == 0) begin
        $display("%0t: unexpected beat: row %0d col %0d edge %0d last %0b", $time,
                 out_chan.out_row, out_chan.out_col, out_chan.edge_pixel,
                 out_chan.last_result);
        fail_count++;
      end else begin
        want = edges_due.pop_front();
        if ({out_chan.out_row, out_chan.out_col, out_chan.edge_pixel,
             out_chan.last_result} !== {want.row, want.col, want.level, want.last}) begin
          $display("%0t: beat mismatch: expected row %0d col %0d edge %0d last %0b,",
                   $time, want.row, want.col, want.level, want.last);
          $display("%0t:   got row %0d col %0d edge %0d last %0b", $time,
                   out_chan.out_row, out_chan.out_col, out_chan.edge_pixel,
                   out_chan.last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin : main_seq
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.pixel       <= '0;
    in_chan.frame_start <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    out_gaps            <= 1'b1;
    hold_seq            <= 0;
    in_gaps = 1;

    // model starts from the reset state
    for (int i = 0; i < LINES; i++)
      for (int j = 0; j < MAX_WIDTH; j++) line_mem[i][j] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) win_mem[i][j] = '0;
    row_pos    = 0;
    col_pos    = 0;
    thresh_reg = THRESH_RESET;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_single_frame();
    test_resize_mid_row();
    test_random_frames();
    test_output_hold();

    wait_drained();
    if (fail_count == 0) begin
      $display("log_edge_threshold_5x5 verification clean");
    end else begin
      $display("log_edge_threshold_5x5 verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIME_LIMIT);
    $display("log_edge_threshold_5x5 verification failed");
    $finish;
  end

endmodule
